@@ hw/rtl/bzf_pkg.sv @@
package bzf_pkg;

    localparam int MAX_POINTS_DEF  = 64;
    localparam int COORD_BITS_DEF  = 32;
    localparam int STACK_LEVELS    = 6;
    localparam int TOP_W           = $clog2(STACK_LEVELS + 1);
    localparam int TOL_W           = 63;
    localparam int BUDGET_W        = 7;
    localparam int POINT_W         = 64;
    localparam int IN_W            = 264;
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(64'd1073741824);

endpackage

@@ hw/rtl/bezier_adaptive_flattener_core.sv @@
// Flatness test: when the point projects outside the chord, the end-point distance runs on the
// pipelined multiplier; otherwise the cross-product test runs on the serial unit.
// Flow: one curve at a time; a new curve is taken only while idle, and an output stall
// holds emission of points.
// Reset: asynchronous active low; clears control state, tolerance to 2^30, block idle.
module bezier_adaptive_flattener_core #(
    parameter int MAX_POINTS = bzf_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = bzf_pkg::COORD_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [bzf_pkg::TOL_W-1:0] cfg_wdata,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [bzf_pkg::IN_W-1:0]  s_tdata,    // pt0, pt1, pt2, pt3, point_budget, pad
    input  logic [0:0]                s_tuser,    // opcode
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [bzf_pkg::POINT_W-1:0] m_tdata,  // out_point
    output logic                      m_tlast
);

    import bzf_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int DW    = CB + 1;
    localparam int PW    = 2 * DW + 1;
    localparam int SW    = (PW > TOL_W) ? PW : TOL_W;
    localparam int NW    = $clog2(MAX_POINTS + 1);
    localparam int ROW_W = 8 * CB + BUDGET_W;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DIFF = 4'd1;
    localparam logic [3:0] ST_UU   = 4'd2;
    localparam logic [3:0] ST_UU2  = 4'd3;
    localparam logic [3:0] ST_ULEN = 4'd4;
    localparam logic [3:0] ST_D1   = 4'd5;
    localparam logic [3:0] ST_DOT  = 4'd6;
    localparam logic [3:0] ST_E1   = 4'd7;
    localparam logic [3:0] ST_E2   = 4'd8;
    localparam logic [3:0] ST_X1   = 4'd9;
    localparam logic [3:0] ST_X2   = 4'd10;
    localparam logic [3:0] ST_SQ   = 4'd11;
    localparam logic [3:0] ST_TU   = 4'd12;
    localparam logic [3:0] ST_DEC  = 4'd13;
    localparam logic [3:0] ST_EMIT = 4'd14;
    localparam logic [3:0] ST_POP  = 4'd15;

    function automatic logic signed [CB-1:0] avg(input logic signed [CB-1:0] a,
                                                 input logic signed [CB-1:0] b);
        logic signed [CB:0] s;
        s = CB'(0) + {a[CB-1], a} + {b[CB-1], b};
        return s[CB:1];
    endfunction

    logic [3:0]              state_reg;
    logic [TOL_W-1:0]        tol_reg;
    logic signed [CB-1:0]    x_reg [4];
    logic signed [CB-1:0]    y_reg [4];
    logic [BUDGET_W-1:0]     budget_reg;
    logic                    cubic_reg;
    logic                    test_reg;
    logic                    flat_reg;
    logic                    use_w_reg;
    logic [TOP_W-1:0]        top_reg;
    logic [NW-1:0]           n_reg;
    logic signed [DW-1:0]    ux_reg, uy_reg, vx_reg, vy_reg, wx_reg, wy_reg;
    logic signed [2*DW-1:0]  t_reg;
    logic signed [PW-1:0]    ulen_reg;
    logic [2*SW-1:0]         detsq_reg;
    logic                    m_tvalid_reg;
    logic [POINT_W-1:0]      m_tdata_reg;
    logic                    m_tlast_reg;

    logic [ROW_W-1:0]        stack_mem [STACK_LEVELS];
    logic [ROW_W-1:0]        rdata_reg;
    logic [ROW_W-1:0]        wrow;
    logic                    push;

    logic signed [DW-1:0]    ma, mb;
    logic signed [2*DW-1:0]  prod;
    logic                    s_start;
    logic [SW-1:0]           s_a, s_b;
    logic                    s_done;
    logic [2*SW-1:0]         s_prod;

    logic signed [CB-1:0]    px, py, bx, by, ex, ey;
    logic signed [PW-1:0]    sum2, diff2, dot;
    logic                    dot_le0, dot_gt;
    logic [PW-1:0]           det_mag;
    logic                    near_e;
    logic                    stack_full;
    logic                    emit_last;
    logic                    emit_go;
    logic [BUDGET_W-1:0]     in_budget;

    logic signed [CB-1:0]    q0x, q0y, q1x, q1y, q2x, q2y, r0x, r0y, r1x, r1y, sx, sy;

    bzf_mul #(.W(DW)) u_mul (
        .clk   (clk),
        .a     (ma),
        .b     (mb),
        .p_reg (prod)
    );

    bzf_smul #(.W(SW)) u_smul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (s_start),
        .a     (s_a),
        .b     (s_b),
        .done  (s_done),
        .prod  (s_prod)
    );

    always_comb
    begin
        px = test_reg ? x_reg[2] : x_reg[1];
        py = test_reg ? y_reg[2] : y_reg[1];
        bx = cubic_reg ? x_reg[3] : x_reg[2];
        by = cubic_reg ? y_reg[3] : y_reg[2];
        ex = bx;
        ey = by;

        sum2    = PW'(t_reg) + PW'(prod);
        diff2   = PW'(t_reg) - PW'(prod);
        dot     = sum2;
        dot_le0 = (dot <= 0);
        dot_gt  = (dot > ulen_reg);
        det_mag = diff2[PW-1] ? PW'(-diff2) : PW'(diff2);
        near_e  = ((2*SW)'($unsigned(sum2)) < (2*SW)'(tol_reg));

        stack_full = (top_reg >= TOP_W'(STACK_LEVELS));
        emit_last  = (top_reg == '0) || ((NW + 1)'(n_reg) + 1'b1 >= (NW + 1)'(MAX_POINTS));
        emit_go    = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);

        in_budget = (s_tdata[256 +: BUDGET_W] > BUDGET_W'(MAX_POINTS)) ?
                    BUDGET_W'(MAX_POINTS) : s_tdata[256 +: BUDGET_W];

        q0x = avg(x_reg[0], x_reg[1]);
        q0y = avg(y_reg[0], y_reg[1]);
        q1x = avg(x_reg[1], x_reg[2]);
        q1y = avg(y_reg[1], y_reg[2]);
        q2x = avg(x_reg[2], x_reg[3]);
        q2y = avg(y_reg[2], y_reg[3]);
        r0x = avg(q0x, q1x);
        r0y = avg(q0y, q1y);
        r1x = avg(q1x, q2x);
        r1y = avg(q1y, q2y);
        sx  = avg(r0x, r1x);
        sy  = avg(r0y, r1y);

        if (cubic_reg)
            wrow = {budget_reg >> 1, y_reg[3], x_reg[3], q2y, q2x, r1y, r1x, sy, sx};
        else
            wrow = {budget_reg >> 1, CB'(0), CB'(0), y_reg[2], x_reg[2], q1y, q1x, r0y, r0x};

        push = (state_reg == ST_DEC) && !(budget_reg < BUDGET_W'(2) || flat_reg || stack_full);

        ma = '0;
        mb = '0;
        case (state_reg)
            ST_UU:   begin ma = ux_reg; mb = ux_reg; end
            ST_UU2:  begin ma = uy_reg; mb = uy_reg; end
            ST_ULEN: begin ma = ux_reg; mb = vx_reg; end
            ST_D1:   begin ma = uy_reg; mb = vy_reg; end
            ST_DOT:
            begin
                if (dot_le0)
                begin
                    ma = vx_reg; mb = vx_reg;
                end
                else if (dot_gt)
                begin
                    ma = wx_reg; mb = wx_reg;
                end
                else
                begin
                    ma = ux_reg; mb = vy_reg;
                end
            end
            ST_E1:
            begin
                ma = use_w_reg ? wy_reg : vy_reg;
                mb = use_w_reg ? wy_reg : vy_reg;
            end
            ST_X1:   begin ma = uy_reg; mb = vx_reg; end
            default: begin ma = '0; mb = '0; end
        endcase

        s_start = 1'b0;
        s_a     = '0;
        s_b     = '0;
        if (state_reg == ST_X2)
        begin
            s_start = 1'b1;
            s_a     = SW'(det_mag);
            s_b     = SW'(det_mag);
        end
        else if (state_reg == ST_SQ && s_done)
        begin
            s_start = 1'b1;
            s_a     = SW'(tol_reg);
            s_b     = SW'($unsigned(ulen_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            stack_mem[top_reg] <= wrow;
        rdata_reg <= stack_mem[top_reg - 1'b1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            tol_reg      <= TOL_RESET;
            for (int i = 0; i < 4; i++)
            begin
                x_reg[i] <= '0;
                y_reg[i] <= '0;
            end
            budget_reg   <= '0;
            cubic_reg    <= 1'b0;
            test_reg     <= 1'b0;
            flat_reg     <= 1'b0;
            use_w_reg    <= 1'b0;
            top_reg      <= '0;
            n_reg        <= '0;
            ux_reg       <= '0;
            uy_reg       <= '0;
            vx_reg       <= '0;
            vy_reg       <= '0;
            wx_reg       <= '0;
            wy_reg       <= '0;
            t_reg        <= '0;
            ulen_reg     <= '0;
            detsq_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tlast_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                tol_reg <= cfg_wdata;
            if (m_tvalid_reg && m_tready && !emit_go)
                m_tvalid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        for (int i = 0; i < 4; i++)
                        begin
                            x_reg[i] <= s_tdata[i*64 + 32 +: CB];
                            y_reg[i] <= s_tdata[i*64 +: CB];
                        end
                        cubic_reg  <= s_tuser[0];
                        budget_reg <= in_budget;
                        top_reg    <= '0;
                        n_reg      <= '0;
                        test_reg   <= 1'b0;
                        state_reg  <= ST_DIFF;
                    end
                end
                ST_DIFF:
                begin
                    ux_reg    <= DW'(bx) - DW'(x_reg[0]);
                    uy_reg    <= DW'(by) - DW'(y_reg[0]);
                    vx_reg    <= DW'(px) - DW'(x_reg[0]);
                    vy_reg    <= DW'(py) - DW'(y_reg[0]);
                    wx_reg    <= DW'(px) - DW'(bx);
                    wy_reg    <= DW'(py) - DW'(by);
                    state_reg <= ST_UU;
                end
                ST_UU:   state_reg <= ST_UU2;
                ST_UU2:
                begin
                    t_reg     <= prod;
                    state_reg <= ST_ULEN;
                end
                ST_ULEN:
                begin
                    ulen_reg  <= sum2;
                    state_reg <= ST_D1;
                end
                ST_D1:
                begin
                    t_reg     <= prod;
                    state_reg <= ST_DOT;
                end
                ST_DOT:
                begin
                    use_w_reg <= !dot_le0 && dot_gt;
                    state_reg <= (dot_le0 || dot_gt) ? ST_E1 : ST_X1;
                end
                ST_E1:
                begin
                    t_reg     <= prod;
                    state_reg <= ST_E2;
                end
                ST_X1:
                begin
                    t_reg     <= prod;
                    state_reg <= ST_X2;
                end
                ST_X2:   state_reg <= ST_SQ;
                ST_SQ:
                begin
                    if (s_done)
                    begin
                        detsq_reg <= s_prod;
                        state_reg <= ST_TU;
                    end
                end
                ST_E2, ST_TU:
                begin
                    if (state_reg == ST_E2 || s_done)
                    begin
                        if (((state_reg == ST_E2) ? near_e : (detsq_reg < s_prod))
                            && cubic_reg && !test_reg)
                        begin
                            test_reg  <= 1'b1;
                            state_reg <= ST_DIFF;
                        end
                        else
                        begin
                            flat_reg  <= (state_reg == ST_E2) ? near_e : (detsq_reg < s_prod);
                            state_reg <= ST_DEC;
                        end
                    end
                end
                ST_DEC:
                begin
                    if (push)
                    begin
                        budget_reg <= budget_reg >> 1;
                        top_reg    <= top_reg + 1'b1;
                        test_reg   <= 1'b0;
                        x_reg[1]   <= q0x;
                        y_reg[1]   <= q0y;
                        if (cubic_reg)
                        begin
                            x_reg[2] <= r0x;
                            y_reg[2] <= r0y;
                            x_reg[3] <= sx;
                            y_reg[3] <= sy;
                        end
                        else
                        begin
                            x_reg[2] <= r0x;
                            y_reg[2] <= r0y;
                        end
                        state_reg  <= ST_DIFF;
                    end
                    else
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (emit_go)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {32'(ex), 32'(ey)};
                        m_tlast_reg  <= emit_last;
                        n_reg        <= n_reg + 1'b1;
                        if (emit_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            top_reg   <= top_reg - 1'b1;
                            state_reg <= ST_POP;
                        end
                    end
                end
                ST_POP:
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        x_reg[i] <= rdata_reg[2*i*CB +: CB];
                        y_reg[i] <= rdata_reg[(2*i+1)*CB +: CB];
                    end
                    budget_reg <= rdata_reg[8*CB +: BUDGET_W];
                    test_reg   <= 1'b0;
                    state_reg  <= ST_DIFF;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

@@ hw/rtl/bzf_mul.sv @@
module bzf_mul #(
    parameter int W = 33
) (
    input  logic                  clk,
    input  logic signed [W-1:0]   a,
    input  logic signed [W-1:0]   b,
    output logic signed [2*W-1:0] p_reg
);

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

endmodule

@@ hw/rtl/bzf_smul.sv @@
module bzf_smul #(
    parameter int W = 67
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [W-1:0]   a,
    input  logic [W-1:0]   b,
    output logic           done,
    output logic [2*W-1:0] prod
);

    localparam int CW = $clog2(W + 1);

    logic [2*W-1:0] acc_reg, acc_next;
    logic [W-1:0]   mcand_reg;
    logic [W-1:0]   mplier_reg;
    logic [CW-1:0]  cnt_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [W:0]     sum;

    always_comb
    begin
        sum      = {1'b0, acc_reg[2*W-1:W]} + (mplier_reg[0] ? {1'b0, mcand_reg} : '0);
        acc_next = {sum, acc_reg[W-1:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            mcand_reg  <= '0;
            mplier_reg <= '0;
            cnt_reg    <= '0;
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else if (start)
        begin
            acc_reg    <= '0;
            mcand_reg  <= a;
            mplier_reg <= b;
            cnt_reg    <= '0;
            busy_reg   <= 1'b1;
            done_reg   <= 1'b0;
        end
        else if (busy_reg)
        begin
            acc_reg    <= acc_next;
            mplier_reg <= mplier_reg >> 1;
            cnt_reg    <= cnt_reg + 1'b1;
            if (cnt_reg == CW'(W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule
